>>> hw/rtl/tcti_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcti_pkg: shared types and constants of the threshold crossing timer
// Item layouts, divider handshake structs, register map and sequencer states.
// ----------------------------------------------------------------------------
package tcti_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int INDEX_W     = 12;
   localparam int FRAC_BITS   = 8;
   localparam int FRAC_W      = FRAC_BITS + 1;
   localparam int PERIOD_W    = 10;
   localparam int TIME_W      = 30;
   localparam int MAX_SAMPLES = 4096;

   localparam int SCALED_W    = INDEX_W + FRAC_BITS + 1;
   localparam int PROD_W      = SCALED_W + PERIOD_W;
   localparam int DIV_REM_W   = SAMPLE_W + 1;
   localparam int DIV_STEP_W  = $clog2(FRAC_BITS + 1);

   localparam logic [INDEX_W-1:0] COUNT_MAX = INDEX_W'(MAX_SAMPLES - 1);

   // register map: register i at byte address 4*i
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 1;
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PERIOD    = 1'd1;

   localparam logic signed [SAMPLE_W-1:0] THRESHOLD_RESET = 16'sd14746;
   localparam logic [PERIOD_W-1:0]        PERIOD_RESET    = 10'd10;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       sample_last;
   } req_payload_type;

   typedef struct packed {
      logic                crossed;
      logic [INDEX_W-1:0]  cross_index;
      logic [FRAC_W-1:0]   cross_fraction;
      logic [TIME_W-1:0]   crossing_time;
   } rsp_payload_type;

   typedef struct packed {
      logic                start;
      logic [SAMPLE_W-1:0] numerator;
      logic [SAMPLE_W-1:0] denominator;
   } div_ctl_type;

   typedef struct packed {
      logic              done;
      logic [FRAC_W-1:0] quotient;
   } div_sts_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_MUL
   } state_type;

endpackage

>>> hw/rtl/tcti_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcti_div: restoring divider for the interpolation fraction
// Computes floor(num * 2^FRAC_BITS / den) for num <= den, one quotient bit
// per cycle through a single compare-and-subtract stage.
// ----------------------------------------------------------------------------
module tcti_div (
   input  logic                  clock,
   input  logic                  reset,
   input  tcti_pkg::div_ctl_type div_ctl,
   output tcti_pkg::div_sts_type div_sts
);
   import tcti_pkg::*;

   logic [DIV_REM_W-1:0]  rem_ff, rem_in;
   logic [SAMPLE_W-1:0]   den_ff, den_in;
   logic [FRAC_W-1:0]     quo_ff, quo_in;
   logic [DIV_STEP_W-1:0] step_ff, step_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;

   logic [DIV_REM_W-1:0]  den_ext;
   logic [DIV_REM_W-1:0]  rest;
   logic                  take;

   assign den_ext = {1'b0, den_ff};
   assign take    = rem_ff >= den_ext;
   assign rest    = take ? (rem_ff - den_ext) : rem_ff;

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      priority if (div_ctl.start) begin
         rem_in  = {1'b0, div_ctl.numerator};
         den_in  = div_ctl.denominator;
         quo_in  = '0;
         step_in = DIV_STEP_W'(FRAC_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so the shift never overflows
         rem_in = rest << 1;
         quo_in = {quo_ff[FRAC_W-2:0], take};
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - DIV_STEP_W'(1);
         end
      end else begin
         // hold while idle
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
   end

   assign div_sts.done     = done_ff;
   assign div_sts.quotient = quo_ff;

endmodule

>>> hw/rtl/threshold_crossing_time_interp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// threshold_crossing_time_interp: leading-edge crossing time of a waveform
// Finds the first upward threshold crossing, interpolates a 1/256 fraction
// and reports the crossing time scaled by the sample period on the last item.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+----------------------------
//   req_     | in        | req_valid / req_ready | sample, sample_last
//   rsp_     | out       | rsp_valid / rsp_ready | crossed, index, fraction, time
//   APB csr  | in/out    | psel, penable, pready | threshold, sample_period
//
// An item without a crossing leaves ST_IDLE ready for the next item. The item that
// completes a crossing holds off new items in ST_DIV while the bit-serial divider
// runs (one quotient bit a cycle). The last item passes through ST_MUL, where the
// multiply result is loaded into the output register; a stalled output holds that
// final step only. Reset is synchronous and clears all waveform state at once.
//
module threshold_crossing_time_interp (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_valid,
   output logic                             req_ready,
   input  tcti_pkg::req_payload_type        req_payload,

   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output tcti_pkg::rsp_payload_type        rsp_payload,

   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [tcti_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [tcti_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [tcti_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready
);
   import tcti_pkg::*;

   logic signed [SAMPLE_W-1:0] threshold_ff;
   logic [PERIOD_W-1:0]        period_ff;

   logic signed [SAMPLE_W-1:0] prev_ff, prev_in;
   logic [INDEX_W-1:0]         count_ff, count_in;
   logic                       found_ff, found_in;
   logic [INDEX_W-1:0]         found_index_ff, found_index_in;
   logic [FRAC_W-1:0]          found_frac_ff, found_frac_in;
   logic                       last_ff, last_in;
   state_type                  state_ff, state_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_payload_type            rsp_payload_ff, rsp_payload_in;

   logic                       accept;
   logic                       csr_write;
   logic [CSR_IDX_W-1:0]       csr_idx;
   logic signed [SAMPLE_W-1:0] cur;
   logic                       hit;
   logic                       saturated;
   logic [SAMPLE_W:0]          num_wide;
   logic [SAMPLE_W:0]          den_wide;
   logic [INDEX_W-1:0]         out_index;
   logic [FRAC_W-1:0]          out_frac;
   logic [SCALED_W-1:0]        scaled;
   logic [PROD_W-1:0]          product;

   div_ctl_type                div_ctl;
   div_sts_type                div_sts;

   // ---------------------------------------------------------------- csr
   assign pready    = 1'b1;
   assign csr_idx   = paddr[2];
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         period_ff    <= PERIOD_RESET;
      end else if (csr_write) begin
         unique case (csr_idx)
            REG_THRESHOLD: threshold_ff <= pwdata[SAMPLE_W-1:0];
            REG_PERIOD:    period_ff    <= pwdata[PERIOD_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_THRESHOLD: prdata = {{(CSR_DATA_W-SAMPLE_W){1'b0}}, threshold_ff};
         REG_PERIOD:    prdata = {{(CSR_DATA_W-PERIOD_W){1'b0}}, period_ff};
      endcase
   end

   // ---------------------------------------------------------- detection
   assign cur       = req_payload.sample;
   assign saturated = count_ff == COUNT_MAX;
   assign hit       = (count_ff != '0) && !found_ff
                      && (prev_ff < threshold_ff) && (cur >= threshold_ff);

   // both differences are positive whenever a crossing is taken
   assign num_wide = {threshold_ff[SAMPLE_W-1], threshold_ff} - {prev_ff[SAMPLE_W-1], prev_ff};
   assign den_wide = {cur[SAMPLE_W-1], cur} - {prev_ff[SAMPLE_W-1], prev_ff};

   assign div_ctl.start       = accept && hit;
   assign div_ctl.numerator   = num_wide[SAMPLE_W-1:0];
   assign div_ctl.denominator = den_wide[SAMPLE_W-1:0];

   tcti_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_ctl (div_ctl),
      .div_sts (div_sts)
   );

   // ------------------------------------------------------------ result
   assign out_index = found_ff ? found_index_ff : count_ff;
   assign out_frac  = found_ff ? found_frac_ff : '0;
   assign scaled    = (SCALED_W'(out_index) << FRAC_BITS) + SCALED_W'(out_frac);
   assign product   = PROD_W'(period_ff) * PROD_W'(scaled);

   // --------------------------------------------------------- sequencer
   assign accept = req_valid && req_ready;

   always_comb begin
      prev_in        = prev_ff;
      count_in       = count_ff;
      found_in       = found_ff;
      found_index_in = found_index_ff;
      found_frac_in  = found_frac_ff;
      last_in        = last_ff;
      state_in       = state_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      req_ready      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               if (hit) begin
                  found_in       = 1'b1;
                  found_index_in = count_ff - INDEX_W'(1);
               end
               if (req_payload.sample_last) begin
                  last_in = 1'b1;
               end else if (saturated) begin
                  // hold the count; block a fresh crossing until the last item
                  prev_in = (found_ff || hit) ? cur : threshold_ff;
               end else begin
                  prev_in  = cur;
                  count_in = count_ff + INDEX_W'(1);
               end
               priority if (hit) begin
                  state_in = ST_DIV;
               end else if (req_payload.sample_last) begin
                  state_in = ST_MUL;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_DIV: begin
            if (div_sts.done) begin
               found_frac_in = div_sts.quotient;
               state_in      = last_ff ? ST_MUL : ST_IDLE;
            end
         end
         ST_MUL: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in                  = 1'b1;
               rsp_payload_in.crossed        = found_ff;
               rsp_payload_in.cross_index    = out_index;
               rsp_payload_in.cross_fraction = out_frac;
               rsp_payload_in.crossing_time  = product[TIME_W-1:0];
               // drop all waveform state for the next item
               prev_in        = '0;
               count_in       = '0;
               found_in       = 1'b0;
               found_index_in = '0;
               found_frac_in  = '0;
               last_in        = 1'b0;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         prev_ff        <= '0;
         count_ff       <= '0;
         found_ff       <= 1'b0;
         found_index_ff <= '0;
         found_frac_ff  <= '0;
         last_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         prev_ff        <= prev_in;
         count_ff       <= count_in;
         found_ff       <= found_in;
         found_index_ff <= found_index_in;
         found_frac_ff  <= found_frac_in;
         last_ff        <= last_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

>>> hw/rtl/tcti_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcti_checker: port-level checks for the threshold crossing timer
// Watches the result channel and the reset behaviour from the top-level ports.
// ----------------------------------------------------------------------------
module tcti_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input tcti_pkg::rsp_payload_type        rsp_payload
);
   import tcti_pkg::*;

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result item changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_frac_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.cross_fraction <= FRAC_W'(1 << FRAC_BITS))
      else $error("fraction beyond one sample");

   a_no_cross_frac: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.crossed |-> rsp_payload.cross_fraction == '0)
      else $error("fraction set without a crossing");

endmodule

bind threshold_crossing_time_interp tcti_checker u_tcti_checker (.*);
